/* hw/rtl/lqr_drive_with_stall_detect_assert.svh */
// Assertion macros shared by the drive controller RTL.
`ifndef LQR_DRIVE_WITH_STALL_DETECT_ASSERT_SVH
`define LQR_DRIVE_WITH_STALL_DETECT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LQRDS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lqrds: implication check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LQRDS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lqrds: next-cycle check failed");

`endif

/* hw/rtl/lqrds_pkg.sv */
// Shared widths, types, constants and rounding helpers for the drive controller.
`timescale 1ns / 1ps
`default_nettype none

package lqrds_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned OPA_W     = 33;
	localparam int unsigned OPB_W     = 32;
	localparam int unsigned PROD_W    = OPA_W + OPB_W;
	localparam int unsigned ACC_W     = 48;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [OPA_W-1:0]  opa_t;
	typedef logic signed [OPB_W-1:0]  opb_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// pi/180 as unsigned Q0.32; positive, so it also fits the signed operand.
	localparam opb_t RAD_PER_DEG = 32'sd74961321;

	localparam logic [CNT_W-1:0] STALL_LIMIT = 9'd500;
	localparam logic [CNT_W-1:0] STALL_SAT   = 9'd511;

	localparam logic [1:0] MODE_RATE  = 2'd1;
	localparam logic [1:0] MODE_ANGLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DMAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DMIN  = 3'd4;

	// Arithmetic shift right by 32, rounding to nearest with ties toward +infinity.
	function automatic opa_t round_shr32(input prod_t p);
		prod_t s;
		s = p + {{(PROD_W-32){1'b0}}, 1'b1, 31'b0};
		return s[32 +: OPA_W];
	endfunction

	// Arithmetic shift right by 16 with the same rounding; the result fits ACC_W.
	function automatic acc_t round_shr16(input prod_t p);
		prod_t s;
		s = p + {{(PROD_W-16){1'b0}}, 1'b1, 15'b0};
		return s[16 +: ACC_W];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/lqr_drive_with_stall_detect.sv */
// Top level of the state-feedback drive controller with stall detection.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, angle_deg, rate_dps,   request in
//             target, feedforward
//   output    out_valid/out_ready, drive, stalled       request out
//   config    cfg_we, cfg_index, cfg_data               write only
//
// A request passes a stall-check step, then a multiply and a round step for each of
// the two (rate mode) or four (angle mode) products on the single shared multiplier,
// then a clamp. An unsupported mode goes from acceptance straight to the clamp.
// The block takes one request at a time.
// The clamp cycle waits while the output register holds a result not yet taken.
// Reset is asynchronous and clears the configuration, stall history and handshakes.
`timescale 1ns / 1ps
`default_nettype none
`include "lqr_drive_with_stall_detect_assert.svh"

module lqr_drive_with_stall_detect (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lqrds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lqrds_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lqrds_pkg::data_t                     angle_deg,
	input  lqrds_pkg::data_t                     rate_dps,
	input  lqrds_pkg::data_t                     target,
	input  lqrds_pkg::data_t                     feedforward,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output lqrds_pkg::data_t                     drive,
	output logic                                 stalled
);
	import lqrds_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_RND   = 3'd3;
	localparam logic [2:0] S_CLAMP = 3'd4;

	logic [2:0]       state_q;
	logic [1:0]       op_q;
	logic [1:0]       mode_q;
	data_t            gain1_q, gain2_q, dmax_q, dmin_q;
	data_t            prev_tgt_q, prev_drive_q;
	logic [CNT_W-1:0] stall_cnt_q;
	logic             stall_flag_q;
	logic             out_valid_q;

	data_t angle_q, rate_q, tgt_q;
	opa_t  rad_q;
	acc_t  acc_q;
	data_t drive_q;
	logic  stalled_q;

	logic  in_acc;
	logic  mode_ok;
	logic  is_rate;
	logic  out_free;
	logic  last_term;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign mode_ok  = (mode_q == MODE_RATE) || (mode_q == MODE_ANGLE);
	assign is_rate  = (mode_q == MODE_RATE);
	assign out_free = !out_valid_q || out_ready;

	// Stall check, evaluated on the registered sample.
	data_t             meas;
	logic [OPA_W-1:0]  pd_ext, abs_pd, tg_ext, abs_ref, diff, abs_diff;
	logic [OPA_W+9:0]  pd_x1000;
	logic [OPA_W+4:0]  diff_x20, ref_x19;
	logic              skip, over;
	logic [CNT_W-1:0]  cnt_inc, cnt_nxt;
	logic              flag_nxt;

	always_comb begin
		meas     = is_rate ? rate_q : angle_q;
		pd_ext   = {prev_drive_q[DATA_W-1], prev_drive_q};
		abs_pd   = pd_ext[OPA_W-1] ? -pd_ext : pd_ext;
		tg_ext   = {prev_tgt_q[DATA_W-1], prev_tgt_q};
		abs_ref  = tg_ext[OPA_W-1] ? -tg_ext : tg_ext;
		diff     = tg_ext - {meas[DATA_W-1], meas};
		abs_diff = diff[OPA_W-1] ? -diff : diff;
		// 1000x = 1024x - 16x - 8x; a negative upper clamp never skips on a small drive.
		pd_x1000 = ({10'b0, abs_pd} << 10) - ({10'b0, abs_pd} << 4)
			- ({10'b0, abs_pd} << 3);
		skip     = (!dmax_q[DATA_W-1] && (pd_x1000 < {11'b0, dmax_q}))
			|| (abs_ref <= 33'd6);
		diff_x20 = ({5'b0, abs_diff} << 4) + ({5'b0, abs_diff} << 2);
		ref_x19  = ({5'b0, abs_ref} << 4) + ({5'b0, abs_ref} << 1) + {5'b0, abs_ref};
		over     = diff_x20 > ref_x19;
		cnt_inc  = (stall_cnt_q == STALL_SAT) ? stall_cnt_q : stall_cnt_q + 9'd1;
		cnt_nxt  = over ? cnt_inc : '0;
		flag_nxt = over ? stall_flag_q : 1'b0;
		if (cnt_nxt > STALL_LIMIT) begin
			flag_nxt = 1'b1;
		end
	end

	// Operand selection for the shared multiplier.
	opa_t  mul_a;
	opb_t  mul_b;
	prod_t prod;

	always_comb begin
		case (op_q)
			2'd0: begin
				mul_a = is_rate ? ({rate_q[DATA_W-1], rate_q} - {tgt_q[DATA_W-1], tgt_q})
					: ({angle_q[DATA_W-1], angle_q} - {tgt_q[DATA_W-1], tgt_q});
				mul_b = RAD_PER_DEG;
			end
			2'd1: begin
				mul_a = rad_q;
				mul_b = gain1_q;
			end
			2'd2: begin
				mul_a = {rate_q[DATA_W-1], rate_q};
				mul_b = RAD_PER_DEG;
			end
			default: begin
				mul_a = rad_q;
				mul_b = gain2_q;
			end
		endcase
	end

	lqrds_mul u_mul (
		.clk  (clk),
		.en   (state_q == S_MUL),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign last_term = (op_q == 2'd3) || ((op_q == 2'd1) && is_rate);

	// Clamp; with an inverted range the lower bound wins.
	data_t clamped;
	acc_t  dmin_ext, dmax_ext;

	always_comb begin
		dmin_ext = {{(ACC_W-DATA_W){dmin_q[DATA_W-1]}}, dmin_q};
		dmax_ext = {{(ACC_W-DATA_W){dmax_q[DATA_W-1]}}, dmax_q};
		if (acc_q <= dmin_ext) begin
			clamped = dmin_q;
		end else if (acc_q >= dmax_ext) begin
			clamped = dmax_q;
		end else begin
			clamped = acc_q[DATA_W-1:0];
		end
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			mode_q       <= MODE_ANGLE;
			gain1_q      <= '0;
			gain2_q      <= '0;
			dmax_q       <= '0;
			dmin_q       <= '0;
			prev_tgt_q   <= '0;
			prev_drive_q <= '0;
			stall_cnt_q  <= '0;
			stall_flag_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MODE:  mode_q  <= cfg_data[1:0];
					REG_GAIN1: gain1_q <= cfg_data;
					REG_GAIN2: gain2_q <= cfg_data;
					REG_DMAX:  dmax_q  <= cfg_data;
					REG_DMIN:  dmin_q  <= cfg_data;
					default: ;
				endcase
			end
			// In the clamp cycle the valid flag is handled below.
			if (out_valid_q && out_ready && (state_q != S_CLAMP)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= '0;
						state_q <= mode_ok ? S_CHECK : S_CLAMP;
					end
				end
				S_CHECK: begin
					if (!skip) begin
						stall_cnt_q  <= cnt_nxt;
						stall_flag_q <= flag_nxt;
					end
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_RND;
				end
				S_RND: begin
					if (!op_q[0] || !last_term) begin
						op_q    <= op_q + 2'd1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (mode_ok) begin
							prev_tgt_q   <= tgt_q;
							prev_drive_q <= clamped;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sample, intermediate and result registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			angle_q <= angle_deg;
			rate_q  <= rate_dps;
			tgt_q   <= target;
			acc_q   <= {{(ACC_W-DATA_W){feedforward[DATA_W-1]}}, feedforward};
		end
		if (state_q == S_RND) begin
			if (!op_q[0]) begin
				rad_q <= round_shr32(prod);
			end else begin
				acc_q <= acc_q - round_shr16(prod);
			end
		end
		if ((state_q == S_CLAMP) && out_free) begin
			stalled_q <= stall_flag_q;
			drive_q   <= (mode_ok && !stall_flag_q) ? clamped : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign stalled   = stalled_q;

	`LQRDS_ASSERT_IMP(a_flag_needs_count, stall_flag_q, stall_cnt_q > STALL_LIMIT)
	`LQRDS_ASSERT_IMP(a_count_sets_flag, stall_cnt_q > STALL_LIMIT, stall_flag_q)
	`LQRDS_ASSERT_IMP(a_stall_zero_drive, out_valid_q && stalled_q, drive_q == '0)
	`LQRDS_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready)
	`LQRDS_ASSERT_IMP(a_rate_two_terms, (state_q == S_MUL) && is_rate, op_q <= 2'd1)

endmodule

`default_nettype wire

/* hw/rtl/lqrds_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module lqrds_mul (
	input  logic             clk,
	input  logic             en,
	input  lqrds_pkg::opa_t  a,
	input  lqrds_pkg::opb_t  b,
	output lqrds_pkg::prod_t prod
);
	import lqrds_pkg::*;

	prod_t prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

/* tb/lqr_drive_with_stall_detect_test.sv */
// Self-checking testbench for the state-feedback drive controller with stall detection.
`timescale 1ns / 1ps

module lqr_drive_with_stall_detect_test;
	import lqrds_pkg::*;

	localparam data_t DATA_MAX = 32'sh7FFF_FFFF;
	localparam data_t DATA_MIN = 32'sh8000_0000;
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam longint TINY_REF = 6;
	localparam int LONG_HOLD = 160;
	localparam int LONG_RUN = 530;
	localparam int SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		data_t drive;
		logic  stalled;
	} drive_result_t;

	typedef enum {BURST_NOISE, BURST_TRACK, BURST_LONG} burst_t;

	// Tracks the controller state and configuration and predicts one result per request.
	class lqr_drive_predictor;
		logic [1:0] mode;
		data_t k_first, k_second, d_max, d_min;
		data_t last_target, last_drive;
		int unsigned stall_cnt;
		bit stall_on;
		drive_result_t expected_drive[$];
		int unsigned mismatches;

		function new();
			mode = MODE_ANGLE;
			k_first = '0;
			k_second = '0;
			d_max = '0;
			d_min = '0;
			last_target = '0;
			last_drive = '0;
			stall_cnt = 0;
			stall_on = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, data_t value);
			case (idx)
				REG_MODE: mode = value[1:0];
				REG_GAIN1: k_first = value;
				REG_GAIN2: k_second = value;
				REG_DMAX: d_max = value;
				REG_DMIN: d_min = value;
				default: ;
			endcase
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// Shift right, rounding to nearest with ties toward plus infinity.
		function longint round_shift(longint v, int k);
			longint half;
			half = longint'(1) << (k - 1);
			if (v >= 0)
				return (v + half) >>> k;
			return -((-v + half - 1) >>> k);
		endfunction

		function longint to_rad(longint deg);
			return round_shift(deg * longint'(RAD_PER_DEG), 32);
		endfunction

		function longint gain_term(data_t gain, longint rad);
			return round_shift(longint'(gain) * rad, 16);
		endfunction

		function int unsigned outstanding();
			return expected_drive.size();
		endfunction

		function void note_request(data_t a, data_t r, data_t t, data_t f);
			longint meas, aref, acc;
			data_t clamped;
			drive_result_t want;
			if (mode != MODE_RATE && mode != MODE_ANGLE) begin
				want.drive = '0;
				want.stalled = stall_on;
				expected_drive.push_back(want);
				return;
			end
			meas = (mode == MODE_RATE) ? longint'(r) : longint'(a);
			aref = mag(longint'(last_target));
			// A negligible previous drive or a tiny previous reference leaves the history alone.
			if (!(mag(longint'(last_drive)) * 1000 < longint'(d_max) || aref <= TINY_REF)) begin
				if (20 * mag(longint'(last_target) - meas) > 19 * aref) begin
					if (stall_cnt < STALL_SAT)
						stall_cnt++;
				end else begin
					stall_cnt = 0;
					stall_on = 1'b0;
				end
				if (stall_cnt > STALL_LIMIT)
					stall_on = 1'b1;
			end
			if (mode == MODE_RATE)
				acc = -gain_term(k_first, to_rad(longint'(r) - longint'(t)));
			else
				acc = -gain_term(k_first, to_rad(longint'(a) - longint'(t)))
					- gain_term(k_second, to_rad(longint'(r)));
			acc += longint'(f);
			// The lower bound is tested first, so it wins when the bounds are inverted.
			if (acc <= longint'(d_min))
				clamped = d_min;
			else if (acc >= longint'(d_max))
				clamped = d_max;
			else
				clamped = data_t'(acc);
			last_target = t;
			last_drive = clamped;
			want.drive = stall_on ? data_t'(0) : clamped;
			want.stalled = stall_on;
			expected_drive.push_back(want);
		endfunction

		function void check_result(data_t d, logic s);
			drive_result_t want;
			if (expected_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: drive %0d stalled %0b", d, s);
				return;
			end
			want = expected_drive.pop_front();
			if (d !== want.drive || s !== want.stalled) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result mismatch: expected drive %0d stalled %0b, got drive %0d stalled %0b",
						want.drive, want.stalled, d, s);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	data_t angle_deg, rate_dps, target, feedforward;
	logic out_valid;
	logic out_ready;
	data_t drive;
	logic stalled;

	bit hold_req = 1'b0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	lqr_drive_predictor law;

	lqr_drive_with_stall_detect dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.angle_deg(angle_deg),
		.rate_dps(rate_dps),
		.target(target),
		.feedforward(feedforward),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive),
		.stalled(stalled)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			law.check_result(drive, stalled);
	end

	// Output side: random stall bursts, calm stretches, and one long hold on demand.
	initial begin : receiver
		int unsigned span;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				span = LONG_HOLD;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				span = $urandom_range(1, 18);
			end else begin
				out_ready <= 1'b1;
				span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
			end
			repeat (span) @(posedge clk);
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Signed value in [-2^bits, 2^bits).
	function automatic data_t rand_span(int bits);
		data_t v;
		v = $urandom;
		return v >>> (31 - bits);
	endfunction

	function automatic data_t any_value();
		case ($urandom_range(0, 7))
			0: return DATA_MAX;
			1: return DATA_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input data_t a, input data_t r, input data_t t, input data_t f);
		in_valid <= 1'b1;
		angle_deg <= a;
		rate_dps <= r;
		target <= t;
		feedforward <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		law.note_request(a, r, t, f);
	endtask

	task automatic settle_outputs();
		in_valid <= 1'b0;
		while (law.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input data_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		law.set_reg(idx, value);
	endtask

	task automatic apply_setting(input logic [1:0] mode, input data_t k1, input data_t k2,
			input data_t hi, input data_t lo);
		write_reg(REG_MODE, {30'b0, mode});
		write_reg(REG_GAIN1, k1);
		write_reg(REG_GAIN2, k2);
		write_reg(REG_DMAX, hi);
		write_reg(REG_DMIN, lo);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		apply_setting(MODE_ANGLE, 32'sh0001_0000, 32'sh0000_8000, DATA_MAX, DATA_MIN);
		send_sample('0, '0, '0, '0);
		send_sample(DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX);
		send_sample(DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
		send_sample('1, '1, '1, '1);
		// References right at and just above the tiny-reference threshold.
		send_sample('0, '0, 32'sd6, 32'sd100);
		send_sample('0, '0, 32'sd7, 32'sd100);
		send_sample('0, '0, 32'sd7, 32'sd100);
		send_sample(32'sd7, 32'sd7, 32'sd7, '0);

		settle_outputs();
		apply_setting(MODE_RATE, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN);
		send_sample(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
		send_sample(DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
		send_sample('0, DATA_MAX, DATA_MIN, '0);

		// Zero gains: drive equals feedforward, so the skip on a small drive can be steered.
		settle_outputs();
		apply_setting(MODE_RATE, '0, '0, 32'sh0010_0000, -32'sh0010_0000);
		send_sample('0, '0, 32'sh0001_0000, '0);
		send_sample('0, '0, 32'sh0001_0000, 32'sh0000_0100);
		send_sample('0, '0, 32'sh0001_0000, 32'sh0000_0800);
		send_sample('0, '0, 32'sh0001_0000, '0);

		settle_outputs();
		apply_setting(MODE_ANGLE, 32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
		send_sample(32'sh0010_0000, '0, '0, '0);
		send_sample(DATA_MIN, '0, DATA_MAX, '0);
		send_sample('0, '0, '0, '0);

		settle_outputs();
		apply_setting(MODE_OFF, 32'sh0001_0000, '0, DATA_MAX, DATA_MIN);
		send_sample(32'sd1, 32'sd2, 32'sd3, 32'sd4);
		settle_outputs();
		apply_setting(MODE_SPARE, 32'sh0001_0000, '0, DATA_MAX, DATA_MIN);
		send_sample(DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
	endtask

	// Mostly runs at a steady reference with the measurement far from it, so the stall
	// counter climbs, with an occasional sample on target that clears it, plus noise.
	task automatic drive_phase(input int count, input int hold_at, input int pause_at,
			input bit long_run);
		int sent;
		int run_len;
		int b;
		int near;
		int i;
		bit gappy;
		burst_t kind;
		data_t tgt, a, r;
		sent = 0;
		b = 12;
		tgt = '0;
		while (sent < count) begin
			gappy = ($urandom_range(0, 2) != 0);
			if (long_run && sent == 0) begin
				kind = BURST_LONG;
				tgt = (($urandom_range(0, 1) == 0) ? 32'sh0040_0000 : -32'sh0040_0000) + rand_span(12);
				run_len = LONG_RUN;
				near = 10;
			end else if ($urandom_range(0, 9) < 7) begin
				kind = BURST_TRACK;
				b = $urandom_range(12, 30);
				tgt = rand_span(b);
				run_len = $urandom_range(4, 40);
				near = b - 6;
			end else begin
				kind = BURST_NOISE;
				run_len = $urandom_range(1, 8);
				near = 0;
			end
			for (i = 0; i < run_len && sent < count; i++) begin
				if (sent == hold_at)
					hold_req = 1'b1;
				if (sent == pause_at)
					settle_outputs();
				if (tx_idle_en && gappy && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 18)) @(posedge clk);
				end
				if (kind == BURST_NOISE) begin
					send_sample(any_value(), any_value(),
						($urandom_range(0, 3) == 0) ? rand_span(3) : any_value(), any_value());
				end else begin
					if (kind == BURST_TRACK && $urandom_range(0, 15) == 0) begin
						a = tgt + rand_span(near);
						r = tgt + rand_span(near);
					end else begin
						a = rand_span(near);
						r = rand_span(near);
					end
					send_sample(a, r, tgt, rand_span($urandom_range(0, 31)));
				end
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		law = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		angle_deg <= '0;
		rate_dps <= '0;
		target <= '0;
		feedforward <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		settle_outputs();
		apply_setting(MODE_ANGLE, rand_span(18), rand_span(18), 32'sh0100_0000, -32'sh0100_0000);
		drive_phase(120, 40, -1, 1'b0);

		settle_outputs();
		apply_setting(MODE_RATE, any_value(), any_value(), DATA_MAX, DATA_MIN);
		drive_phase(120, -1, 70, 1'b0);

		// A negative upper clamp never lets a small drive skip the check, so the flag can set.
		settle_outputs();
		apply_setting(MODE_ANGLE, rand_span(20), rand_span(20), -32'sh0000_0100, -32'sh4000_0000);
		drive_phase(540, -1, -1, 1'b1);

		settle_outputs();
		apply_setting(MODE_RATE, rand_span(16), rand_span(16), -32'sh0000_8000, 32'sh0000_8000);
		drive_phase(50, -1, -1, 1'b0);

		settle_outputs();
		apply_setting(MODE_OFF, rand_span(16), rand_span(16), DATA_MAX, DATA_MIN);
		drive_phase(10, -1, -1, 1'b0);
		settle_outputs();
		apply_setting(MODE_SPARE, rand_span(16), rand_span(16), DATA_MAX, DATA_MIN);
		drive_phase(10, -1, -1, 1'b0);

		settle_outputs();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		apply_setting(MODE_ANGLE, rand_span(24), rand_span(24), rand_span(30) & DATA_MAX,
			-(rand_span(30) & DATA_MAX));
		drive_phase(80, -1, -1, 1'b0);

		settle_outputs();
		if (law.mismatches == 0 && law.outstanding() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
